// ===== rtl/mpl_pkg.sv =====
`default_nettype none
package mpl_pkg;

	// field widths
	localparam int ID_W  = 10;
	localparam int QW    = 16;
	localparam int PW    = 24;
	localparam int YAW_W = 16;
	localparam int OFS_W = 16;

	// parameter defaults
	localparam int MARKER_IDS_DEF    = 1024;
	localparam int CORDIC_ROUNDS_DEF = 16;

	// divider widths: magnitude and norm up to 2^32, quotient up to 2^30
	localparam int DEN_W = 33;
	localparam int FRAC  = 30;
	localparam int QUO_W = FRAC + 1;

	// cordic datapath width
	localparam int CW = 36;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30     = 36'sd1073741824;

	// request opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DETECT = 1'b1;

	// register indexes
	localparam logic [1:0] REG_CAM_X = 2'd0;
	localparam logic [1:0] REG_CAM_Y = 2'd1;
	localparam logic [1:0] REG_CAM_Z = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] mag;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic                 start;
		logic                 vec;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cor_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cor_rsp_t;

	// arctangent of 2^-i in units of pi/2^31
	function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
		logic signed [CW-1:0] v;
		unique case (idx)
			5'd0:  v = 36'sd536870912;
			5'd1:  v = 36'sd316933406;
			5'd2:  v = 36'sd167458907;
			5'd3:  v = 36'sd85004756;
			5'd4:  v = 36'sd42667331;
			5'd5:  v = 36'sd21354465;
			5'd6:  v = 36'sd10679838;
			5'd7:  v = 36'sd5340245;
			5'd8:  v = 36'sd2670163;
			5'd9:  v = 36'sd1335087;
			5'd10: v = 36'sd667544;
			5'd11: v = 36'sd333772;
			5'd12: v = 36'sd166886;
			5'd13: v = 36'sd83443;
			5'd14: v = 36'sd41722;
			5'd15: v = 36'sd20861;
			5'd16: v = 36'sd10430;
			5'd17: v = 36'sd5215;
			5'd18: v = 36'sd2608;
			5'd19: v = 36'sd1304;
			5'd20: v = 36'sd652;
			5'd21: v = 36'sd326;
			5'd22: v = 36'sd163;
			5'd23: v = 36'sd81;
			5'd24: v = 36'sd41;
			5'd25: v = 36'sd20;
			5'd26: v = 36'sd10;
			5'd27: v = 36'sd5;
			5'd28: v = 36'sd3;
			5'd29: v = 36'sd1;
			5'd30: v = 36'sd1;
			5'd31: v = 36'sd0;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mpl_item_if.sv =====
`default_nettype none
interface mpl_item_if
	import mpl_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [ID_W-1:0]      tag_id;
	logic signed [QW-1:0] quat_w;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;
	logic signed [PW-1:0] pos_x;
	logic signed [PW-1:0] pos_y;
	logic signed [PW-1:0] pos_z;

	modport source (output valid, op, tag_id, quat_w, quat_x, quat_y, quat_z,
		pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, op, tag_id, quat_w, quat_x, quat_y, quat_z,
		pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/mpl_pose_if.sv =====
`default_nettype none
interface mpl_pose_if
	import mpl_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [ID_W-1:0]         seen_id;
	logic signed [PW-1:0]    robot_x;
	logic signed [PW-1:0]    robot_y;
	logic signed [PW-1:0]    robot_z;
	logic signed [YAW_W-1:0] robot_yaw;
	logic signed [QW-1:0]    yaw_quat_z;
	logic signed [QW-1:0]    yaw_quat_w;

	modport source (output valid, seen_id, robot_x, robot_y, robot_z, robot_yaw,
		yaw_quat_z, yaw_quat_w, input ready);
	modport sink (input valid, seen_id, robot_x, robot_y, robot_z, robot_yaw,
		yaw_quat_z, yaw_quat_w, output ready);
endinterface
`default_nettype wire

// ===== rtl/marker_pose_localizer.sv =====
`default_nettype none
// Robot pose from a fiducial marker sighting. A load request (op 0) writes one marker's world
// pose into the table as it is accepted. A detection request (op 1) of a known marker goes from
// acceptance through a table check, quaternion products, eighteen rotation-matrix divisions on
// the one-bit-per-cycle divider (which sets most of the latency; a zero quaternion skips its nine
// divisions), multiply-accumulate on the shared multiplier for the matrix and translation
// products and two CORDIC passes to the output register. Unknown or out-of-range ids return to
// idle with no result. Input ready is high only while the sequencer is idle; a finished pose
// waits in the output register while the next request is taken, and a second pose stalls the
// sequencer until the first is taken. After reset the table is cleared one entry a cycle, with
// input ready low; register writes are taken throughout.
module marker_pose_localizer
	import mpl_pkg::*;
#(
	parameter int MARKER_IDS    = MARKER_IDS_DEF,
	parameter int CORDIC_ROUNDS = CORDIC_ROUNDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	mpl_item_if.sink         item,
	mpl_pose_if.source       pose
);
	localparam int AW    = (MARKER_IDS > 1) ? $clog2(MARKER_IDS) : 1;
	localparam int ENT_W = 1 + 4*QW + 3*PW;
	localparam int MW    = 33;
	localparam int PRW   = 2*MW;
	localparam int ACC_W = PRW + 2;

	localparam logic [4:0] S_CLEAR   = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_CHECK   = 5'd2;
	localparam logic [4:0] S_QMUL    = 5'd3;
	localparam logic [4:0] S_QSTORE  = 5'd4;
	localparam logic [4:0] S_DIVGO   = 5'd5;
	localparam logic [4:0] S_DIVWAIT = 5'd6;
	localparam logic [4:0] S_MMUL    = 5'd7;
	localparam logic [4:0] S_MACC    = 5'd8;
	localparam logic [4:0] S_TMUL    = 5'd9;
	localparam logic [4:0] S_TACC    = 5'd10;
	localparam logic [4:0] S_ATAN    = 5'd11;
	localparam logic [4:0] S_ATWAIT  = 5'd12;
	localparam logic [4:0] S_ROT     = 5'd13;
	localparam logic [4:0] S_ROTWAIT = 5'd14;
	localparam logic [4:0] S_OUT     = 5'd15;

	function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
		return 4'({2'b00, r} * 4'd3 + {2'b00, c});
	endfunction

	// round(v / 2^30), half away from zero
	function automatic logic signed [39:0] rnd30(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] m, r;
		m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		r = (m + (ACC_W'(1) << 29)) >> 30;
		return v[ACC_W-1] ? -40'(r) : 40'(r);
	endfunction

	// round(v / 2^16), half away from zero
	function automatic logic signed [CW-1:0] rnd16(input logic signed [CW-1:0] v);
		logic [CW-1:0] m, r;
		m = v[CW-1] ? CW'(-v) : CW'(v);
		r = (m + (CW'(1) << 15)) >> 16;
		return v[CW-1] ? -CW'(r) : CW'(r);
	endfunction

	function automatic logic signed [QW-1:0] clamp14(input logic signed [CW-1:0] v);
		if (v > 36'sd16384) begin
			return 16'sd16384;
		end else if (v < -36'sd16384) begin
			return -16'sd16384;
		end
		return QW'(v);
	endfunction

	// configuration registers
	logic signed [OFS_W-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CAM_X: cam_x_q <= pwdata[OFS_W-1:0];
				REG_CAM_Y: cam_y_q <= pwdata[OFS_W-1:0];
				REG_CAM_Z: cam_z_q <= pwdata[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CAM_X: prdata = 32'(cam_x_q);
			REG_CAM_Y: prdata = 32'(cam_y_q);
			REG_CAM_Z: prdata = 32'(cam_z_q);
			default:   prdata = '0;
		endcase
	end

	// sequencer state and counters
	logic [4:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [3:0]    pidx_q, eidx_q;
	logic          which_q;
	logic [1:0]    mi_q, mj_q, mk_q;
	logic          out_valid_q;

	// datapath registers
	logic [ID_W-1:0]         id_q;
	logic signed [QW-1:0]    cq_q [4];
	logic signed [PW-1:0]    cp_q [3];
	logic signed [PRW-1:0]   prod_q;
	logic signed [31:0]      qp_q [10];
	logic                    sign_q;
	logic signed [31:0]      rc_q [9];
	logic signed [31:0]      rw_q [9];
	logic signed [31:0]      rwv_q [9];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PW-1:0]    res_q [3];
	logic signed [YAW_W-1:0] yaw_q;
	logic signed [QW-1:0]    yqz_q, yqw_q;
	logic [ID_W-1:0]         o_id_q;
	logic signed [PW-1:0]    o_x_q, o_y_q, o_z_q;
	logic signed [YAW_W-1:0] o_yaw_q;
	logic signed [QW-1:0]    o_qz_q, o_qw_q;

	// marker table: present bit, quaternion, position
	logic             accept, in_range;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr;
	logic [ENT_W-1:0] ram_wdata, ram_rdata;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign in_range   = 17'(item.tag_id) < 17'(MARKER_IDS);
	assign ram_we     = (state_q == S_CLEAR) || (accept && in_range && item.op == OP_LOAD);
	assign ram_re     = accept && in_range && item.op == OP_DETECT;
	assign ram_waddr  = (state_q == S_CLEAR) ? clr_q : AW'(item.tag_id);
	assign ram_wdata  = (state_q == S_CLEAR) ? '0 :
		{1'b1, item.quat_w, item.quat_x, item.quat_y, item.quat_z,
		item.pos_x, item.pos_y, item.pos_z};

	mpl_ram #(.W(ENT_W), .D(MARKER_IDS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(item.tag_id)),
		.rdata (ram_rdata)
	);

	// quaternion source: camera first, then the marker's world entry
	logic signed [QW-1:0] qsel [4];
	logic signed [PW-1:0] pw [3];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qsel[k] = which_q ? ram_rdata[ENT_W-2-k*QW -: QW] : cq_q[k];
		end
		for (int k = 0; k < 3; k++) begin
			pw[k] = ram_rdata[(3-k)*PW-1 -: PW];
		end
	end

	// product pairs: ww xx yy zz xy wz xz wy yz wx
	logic [1:0] pa, pb;

	always_comb begin
		unique case (pidx_q)
			4'd0:    begin pa = 2'd0; pb = 2'd0; end
			4'd1:    begin pa = 2'd1; pb = 2'd1; end
			4'd2:    begin pa = 2'd2; pb = 2'd2; end
			4'd3:    begin pa = 2'd3; pb = 2'd3; end
			4'd4:    begin pa = 2'd1; pb = 2'd2; end
			4'd5:    begin pa = 2'd0; pb = 2'd3; end
			4'd6:    begin pa = 2'd1; pb = 2'd3; end
			4'd7:    begin pa = 2'd0; pb = 2'd2; end
			4'd8:    begin pa = 2'd2; pb = 2'd3; end
			4'd9:    begin pa = 2'd0; pb = 2'd1; end
			default: begin pa = 2'd0; pb = 2'd0; end
		endcase
	end

	// unnormalized rotation entry and norm
	logic signed [34:0] p [10];
	logic signed [34:0] mm, nsum;
	logic [DEN_W-1:0]   mmag, nrm;
	logic               n_zero;

	always_comb begin
		for (int k = 0; k < 10; k++) begin
			p[k] = 35'(qp_q[k]);
		end
		unique case (eidx_q)
			4'd0:    mm = p[0] + p[1] - p[2] - p[3];
			4'd1:    mm = (p[4] - p[5]) <<< 1;
			4'd2:    mm = (p[6] + p[7]) <<< 1;
			4'd3:    mm = (p[4] + p[5]) <<< 1;
			4'd4:    mm = p[0] - p[1] + p[2] - p[3];
			4'd5:    mm = (p[8] - p[9]) <<< 1;
			4'd6:    mm = (p[6] - p[7]) <<< 1;
			4'd7:    mm = (p[8] + p[9]) <<< 1;
			4'd8:    mm = p[0] - p[1] - p[2] + p[3];
			default: mm = '0;
		endcase
		nsum   = p[0] + p[1] + p[2] + p[3];
		nrm    = nsum[DEN_W-1:0];
		mmag   = mm[34] ? DEN_W'(-mm) : DEN_W'(mm);
		n_zero = (nrm == '0);
	end

	// shared divider
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign div_req.start = (state_q == S_DIVGO) && !n_zero;
	assign div_req.mag   = mmag;
	assign div_req.den   = nrm;

	mpl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// rotation entry write: zero norm gives identity
	logic               rot_wr, rot_last;
	logic signed [31:0] rot_val, quo_s;

	assign quo_s    = 32'({1'b0, div_rsp.quo});
	assign rot_wr   = ((state_q == S_DIVGO) && n_zero) || ((state_q == S_DIVWAIT) && div_rsp.done);
	assign rot_last = (eidx_q == 4'd8);

	always_comb begin
		if (state_q == S_DIVGO) begin
			rot_val = (eidx_q == 4'd0 || eidx_q == 4'd4 || eidx_q == 4'd8) ?
				32'(ONE_Q30) : 32'sd0;
		end else begin
			rot_val = sign_q ? -quo_s : quo_s;
		end
	end

	// shared multiplier operands
	logic signed [MW-1:0] mul_a, mul_b, rc_op;
	logic signed [24:0]   pv;
	logic [1:0]           rv_row;

	always_comb begin
		unique case (mk_q)
			2'd0:    pv = 25'(cp_q[2]) + 25'(cam_x_q);
			2'd1:    pv = -25'(cp_q[0]) + 25'(cam_y_q);
			2'd2:    pv = -25'(cp_q[1]) + 25'(cam_z_q);
			default: pv = '0;
		endcase
		unique case (mj_q)
			2'd0:    rv_row = 2'd2;
			2'd1:    rv_row = 2'd0;
			default: rv_row = 2'd1;
		endcase
		rc_op = MW'(rc_q[idx3(rv_row, mk_q)]);
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_QMUL) begin
			mul_a = MW'(qsel[pa]);
			mul_b = MW'(qsel[pb]);
		end else if (state_q == S_MMUL) begin
			mul_a = MW'(rw_q[idx3(mi_q, mk_q)]);
			mul_b = (mj_q == 2'd0) ? rc_op : -rc_op;
		end else if (state_q == S_TMUL) begin
			mul_a = MW'(rwv_q[idx3(mi_q, mk_q)]);
			mul_b = MW'(pv);
		end
	end

	// accumulate, round and saturate
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [39:0]      acc_rnd;
	logic signed [41:0]      diff;
	logic signed [PW-1:0]    diff_sat;

	always_comb begin
		acc_sum = acc_q + ACC_W'(prod_q);
		acc_rnd = rnd30(acc_sum);
		diff    = 42'(pw[mi_q]) - 42'(acc_rnd);
		if (diff > 42'sd8388607) begin
			diff_sat = 24'sh7fffff;
		end else if (diff < -42'sd8388608) begin
			diff_sat = 24'sh800000;
		end else begin
			diff_sat = PW'(diff);
		end
	end

	// shared cordic: vectoring for yaw, rotation for the half-angle quaternion
	cor_req_t cor_req;
	cor_rsp_t cor_rsp;
	logic     yaw_degen;

	assign yaw_degen     = (rwv_q[0] == 32'sd0) && (rwv_q[3] == 32'sd0);
	assign cor_req.start = ((state_q == S_ATAN) && !yaw_degen) || (state_q == S_ROT);
	assign cor_req.vec   = (state_q == S_ATAN);
	assign cor_req.x     = (state_q == S_ATAN) ? CW'(rwv_q[0]) : CORDIC_GAIN;
	assign cor_req.y     = (state_q == S_ATAN) ? CW'(rwv_q[3]) : '0;
	assign cor_req.z     = (state_q == S_ATAN) ? '0 : (CW'(yaw_q) <<< 15);

	mpl_cordic #(.ROUNDS(CORDIC_ROUNDS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || pose.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pidx_q      <= '0;
			eidx_q      <= '0;
			which_q     <= 1'b0;
			mi_q        <= '0;
			mj_q        <= '0;
			mk_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MARKER_IDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (ram_re) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					which_q <= 1'b0;
					pidx_q  <= '0;
					state_q <= ram_rdata[ENT_W-1] ? S_QMUL : S_IDLE;
				end
				S_QMUL: state_q <= S_QSTORE;
				S_QSTORE: begin
					pidx_q <= pidx_q + 4'd1;
					if (pidx_q == 4'd9) begin
						eidx_q  <= '0;
						state_q <= S_DIVGO;
					end else begin
						state_q <= S_QMUL;
					end
				end
				S_DIVGO, S_DIVWAIT: begin
					if (state_q == S_DIVGO && !n_zero) begin
						state_q <= S_DIVWAIT;
					end else if (rot_wr) begin
						if (!rot_last) begin
							eidx_q  <= eidx_q + 4'd1;
							state_q <= S_DIVGO;
						end else if (!which_q) begin
							which_q <= 1'b1;
							pidx_q  <= '0;
							state_q <= S_QMUL;
						end else begin
							mi_q    <= '0;
							mj_q    <= '0;
							mk_q    <= '0;
							state_q <= S_MMUL;
						end
					end
				end
				S_MMUL: state_q <= S_MACC;
				S_MACC: begin
					state_q <= S_MMUL;
					if (mk_q == 2'd2) begin
						mk_q <= '0;
						if (mj_q == 2'd2) begin
							mj_q <= '0;
							if (mi_q == 2'd2) begin
								mi_q    <= '0;
								state_q <= S_TMUL;
							end else begin
								mi_q <= mi_q + 2'd1;
							end
						end else begin
							mj_q <= mj_q + 2'd1;
						end
					end else begin
						mk_q <= mk_q + 2'd1;
					end
				end
				S_TMUL: state_q <= S_TACC;
				S_TACC: begin
					state_q <= S_TMUL;
					if (mk_q == 2'd2) begin
						mk_q <= '0;
						if (mi_q == 2'd2) begin
							state_q <= S_ATAN;
						end else begin
							mi_q <= mi_q + 2'd1;
						end
					end else begin
						mk_q <= mk_q + 2'd1;
					end
				end
				S_ATAN: state_q <= yaw_degen ? S_ROT : S_ATWAIT;
				S_ATWAIT: begin
					if (cor_rsp.done) begin
						state_q <= S_ROT;
					end
				end
				S_ROT: state_q <= S_ROTWAIT;
				S_ROTWAIT: begin
					if (cor_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			id_q     <= item.tag_id;
			cq_q[0]  <= item.quat_w;
			cq_q[1]  <= item.quat_x;
			cq_q[2]  <= item.quat_y;
			cq_q[3]  <= item.quat_z;
			cp_q[0]  <= item.pos_x;
			cp_q[1]  <= item.pos_y;
			cp_q[2]  <= item.pos_z;
		end
		if (state_q == S_CHECK) begin
			acc_q <= '0;
		end
		if (state_q == S_QSTORE) begin
			qp_q[pidx_q] <= prod_q[31:0];
		end
		if (state_q == S_DIVGO) begin
			sign_q <= mm[34];
		end
		if (rot_wr) begin
			if (which_q) begin
				rw_q[eidx_q] <= rot_val;
			end else begin
				rc_q[eidx_q] <= rot_val;
			end
		end
		if (state_q == S_MACC || state_q == S_TACC) begin
			acc_q <= (mk_q == 2'd2) ? '0 : acc_sum;
		end
		if (state_q == S_MACC && mk_q == 2'd2) begin
			rwv_q[idx3(mi_q, mj_q)] <= acc_rnd[31:0];
		end
		if (state_q == S_TACC && mk_q == 2'd2) begin
			res_q[mi_q] <= diff_sat;
		end
		if (state_q == S_ATAN && yaw_degen) begin
			yaw_q <= '0;
		end
		if (state_q == S_ATWAIT && cor_rsp.done) begin
			yaw_q <= YAW_W'(rnd16(cor_rsp.z));
		end
		if (state_q == S_ROTWAIT && cor_rsp.done) begin
			yqz_q <= clamp14(rnd16(cor_rsp.y));
			yqw_q <= clamp14(rnd16(cor_rsp.x));
		end
		if (out_load) begin
			o_id_q  <= id_q;
			o_x_q   <= res_q[0];
			o_y_q   <= res_q[1];
			o_z_q   <= res_q[2];
			o_yaw_q <= yaw_q;
			o_qz_q  <= yqz_q;
			o_qw_q  <= yqw_q;
		end
	end

	// result channel
	assign pose.valid      = out_valid_q;
	assign pose.seen_id    = o_id_q;
	assign pose.robot_x    = o_x_q;
	assign pose.robot_y    = o_y_q;
	assign pose.robot_z    = o_z_q;
	assign pose.robot_yaw  = o_yaw_q;
	assign pose.yaw_quat_z = o_qz_q;
	assign pose.yaw_quat_w = o_qw_q;
endmodule
`default_nettype wire

// ===== rtl/mpl_ram.sv =====
`default_nettype none
module mpl_ram
	import mpl_pkg::*;
#(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/mpl_div.sv =====
`default_nettype none
module mpl_div
	import mpl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	localparam int NW = DEN_W + FRAC;

	logic             busy_q, done_q;
	logic [4:0]       cnt_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [QUO_W-1:0] low_q, quo_q;
	logic [NW-1:0]    num;
	logic [DEN_W:0]   trial;
	logic             ge;

	// rounded numerator: mag * 2^30 + den / 2
	assign num   = {req.mag, {FRAC{1'b0}}} + NW'(req.den >> 1);
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DEN_W'(num[NW-1:QUO_W]);
			low_q <= num[QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/mpl_cordic.sv =====
`default_nettype none
module mpl_cordic
	import mpl_pkg::*;
#(
	parameter int ROUNDS = CORDIC_ROUNDS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cor_req_t req,
	output cor_rsp_t      rsp
);
	localparam int CNT_W = $clog2(ROUNDS + 1);

	logic                 busy_q, done_q, vec_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [4:0]           sh;
	logic signed [CW-1:0] dx, dy, at, x_n, y_n, z_n;
	logic                 up;

	// one micro-rotation
	always_comb begin
		sh = 5'(cnt_q);
		dx = y_q >>> sh;
		dy = x_q >>> sh;
		at = atan_entry(sh);
		if (vec_q) begin
			up  = y_q > 0;
			x_n = up ? x_q + dx : x_q - dx;
			y_n = up ? y_q - dy : y_q + dy;
			z_n = up ? z_q + at : z_q - at;
		end else begin
			up  = z_q >= 0;
			x_n = up ? x_q - dx : x_q + dx;
			y_n = up ? y_q + dy : y_q - dy;
			z_n = up ? z_q - at : z_q + at;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// vectoring start folds the left half plane by a quarter turn
	always_ff @(posedge clk) begin
		if (req.start) begin
			vec_q <= req.vec;
			if (req.vec && req.x < 0) begin
				if (req.y >= 0) begin
					x_q <= req.y;
					y_q <= -req.x;
					z_q <= ONE_Q30;
				end else begin
					x_q <= -req.y;
					y_q <= req.x;
					z_q <= -ONE_Q30;
				end
			end else begin
				x_q <= req.x;
				y_q <= req.y;
				z_q <= req.z;
			end
		end else if (busy_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign rsp.z    = z_q;
endmodule
`default_nettype wire
